/* src/wtc_pkg.sv */
// package for the weighted threshold cache
// holds widths, sizes, constants and the entry type; no dependencies
package wtc_pkg;
  localparam int unsigned Capacity = 128;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DistW    = 32;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned SumW     = 39;
  localparam int unsigned ThrW     = 33;
  localparam int unsigned FracW    = 17;
  localparam int unsigned DivW     = SumW + 16;
  localparam logic [ThrW-1:0] AcceptAllThr = 33'h1_FFFF_0000;
  localparam logic [FracW-1:0] FracMax = 17'h10000;

  typedef struct packed {
    logic [DistW-1:0]   score;
    logic               lab;
    logic [WeightW-1:0] weight;
  } entry_t;
endpackage

/* src/wtc_if.sv */
// valid/ready channel interface with a parameterless payload type
// depends on wtc_pkg
interface wtc_in_if;
  import wtc_pkg::*;
  logic               valid;
  logic               ready;
  logic [DistW-1:0]   sample_distance;
  logic               label_positive;
  logic [WeightW-1:0] sample_weight;
  modport source (output valid, sample_distance, label_positive, sample_weight, input ready);
  modport sink   (input valid, sample_distance, label_positive, sample_weight, output ready);
endinterface

interface wtc_out_if;
  import wtc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ThrW-1:0]  best_threshold;
  logic [SumW-1:0]  error_weight;
  logic [FracW-1:0] error_fraction;
  modport source (output valid, best_threshold, error_weight, error_fraction, input ready);
  modport sink   (input valid, best_threshold, error_weight, error_fraction, output ready);
endinterface

/* src/weighted_threshold_cache_top.sv */
// Weighted threshold cache: keeps up to 128 labelled, weighted scores sorted
// by score and after every item returns the threshold with least misclassified
// weight. One item at a time, with n entries cached before the item: the accept
// step, a scan of n entries (skipped when empty; one memory read a cycle, finds
// insert place and lightest entry), a decide step, a shift of up to 127 entries
// between the freed slot and the new one, one write of the new entry (shift and
// write skipped for a dropped item), a sweep of all entries, a final step and a
// 55-step restoring divide, then the result waits for out_o.ready. in_i.ready is
// high only between items.
// depends on wtc_pkg and wtc_if
module weighted_threshold_cache_top
  import wtc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  wtc_in_if.sink    in_i,
  wtc_out_if.source out_o
);
  localparam logic [3:0] SIdle = 4'd0, SScan = 4'd1, SDecide = 4'd2, SShRd = 4'd3,
    SShWr = 4'd4, SPut = 4'd5, SSweep = 4'd6, SFinal = 4'd7, SDiv = 4'd8, SOut = 4'd9;

  entry_t mem [Capacity];
  entry_t rd_q;
  logic [IdxW-1:0] raddr, waddr;
  logic we;
  entry_t wdata;

  logic [3:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, i_q;
  logic [SumW-1:0] psum_q, nsum_q, fr_q, fa_q, err_q;
  logic [DistW-1:0] d_q;
  logic lab_q;
  logic [WeightW-1:0] w_q, minw_q;
  logic [CntW-1:0] pos_q, minidx_q, j_q;
  logic [ThrW-1:0] thr_q;
  logic [DistW-1:0] gd_q;
  logic first_q, evict_q, dir_up_q;
  logic [DivW-1:0] rem_q, quo_q;
  logic [SumW:0] tot_q;
  logic [5:0] dc_q;
  entry_t ev_q;

  logic full, drop, evict;
  logic [CntW-1:0] hole, slot, jn, jnn;
  logic [SumW-1:0] cur, best;
  logic [DivW:0] trial;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign full  = (cnt_q == CntW'(Capacity));
  assign drop  = full && (w_q <= minw_q);
  assign evict = full && (w_q > minw_q);
  // entries between the freed slot and the new slot move one place toward the freed one
  assign hole  = evict ? minidx_q : cnt_q;
  assign slot  = (evict && d_q > ev_q.score) ? pos_q - 1'b1 : pos_q;
  assign jn    = dir_up_q ? j_q - 1'b1 : j_q + 1'b1;
  assign jnn   = dir_up_q ? jn - 1'b1 : jn + 1'b1;
  assign cur   = fr_q + fa_q;
  assign best  = (fa_q < err_q) ? fa_q : err_q;
  assign trial = {rem_q, quo_q[DivW-1]} - {{(DivW-SumW){1'b0}}, tot_q};

  always_comb begin
    st_d  = st_q;
    raddr = i_q[IdxW-1:0];
    we    = 1'b0;
    waddr = j_q[IdxW-1:0];
    wdata = rd_q;
    case (st_q)
      SIdle:   if (in_i.valid) st_d = (cnt_q == '0) ? SDecide : SScan;
      SScan:   if (i_q == cnt_q) st_d = SDecide;
      SDecide: begin
        if (drop) st_d = SSweep;
        else if (hole == slot) st_d = SPut;
        else st_d = SShRd;
      end
      SShRd: begin
        // fetch the source of the first slot to fill
        raddr = jn[IdxW-1:0];
        st_d = SShWr;
      end
      SShWr: begin
        we = 1'b1;
        raddr = jnn[IdxW-1:0];
        if (jn == pos_q) st_d = SPut;
      end
      SPut: begin
        we = 1'b1;
        waddr = pos_q[IdxW-1:0];
        wdata = '{score: d_q, lab: lab_q, weight: w_q};
        st_d = SSweep;
      end
      SSweep:  if (i_q == cnt_q) st_d = SFinal;
      SFinal:  st_d = SDiv;
      SDiv:    if (dc_q == '0) st_d = SOut;
      SOut:    if (out_o.ready) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cnt_q <= '0;
      psum_q <= '0;
      nsum_q <= '0;
      i_q <= '0;
      j_q <= '0;
      d_q <= '0;
      lab_q <= 1'b0;
      w_q <= '0;
      minw_q <= '0;
      pos_q <= '0;
      minidx_q <= '0;
      ev_q <= '0;
      first_q <= 1'b0;
      evict_q <= 1'b0;
      dir_up_q <= 1'b0;
      fr_q <= '0;
      fa_q <= '0;
      err_q <= '0;
      thr_q <= '0;
      gd_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      tot_q <= '0;
      dc_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        SIdle: if (in_i.valid) begin
          d_q <= in_i.sample_distance;
          lab_q <= in_i.label_positive;
          w_q <= in_i.sample_weight;
          i_q <= '0;
          pos_q <= '0;
          minidx_q <= '0;
          first_q <= 1'b1;
        end
        SScan: begin
          // data for entry i_q-1 arrives in the cycle after its read
          if (i_q != '0) begin
            if (first_q || rd_q.weight < minw_q) begin
              minw_q <= rd_q.weight;
              minidx_q <= i_q - 1'b1;
              ev_q <= rd_q;
            end
            first_q <= 1'b0;
            if (d_q > rd_q.score) pos_q <= i_q;
          end
          if (i_q != cnt_q) i_q <= i_q + 1'b1;
        end
        SDecide: begin
          evict_q <= evict;
          if (evict) begin
            if (ev_q.lab) psum_q <= psum_q - SumW'(ev_q.weight);
            else nsum_q <= nsum_q - SumW'(ev_q.weight);
          end
          pos_q <= slot;
          j_q <= hole;
          dir_up_q <= (slot < hole);
          i_q <= '0;
        end
        SShWr: j_q <= jn;
        SPut: begin
          if (!evict_q) cnt_q <= cnt_q + 1'b1;
          if (lab_q) psum_q <= psum_q + SumW'(w_q);
          else nsum_q <= nsum_q + SumW'(w_q);
        end
        SSweep: begin
          if (i_q == '0) begin
            fr_q <= psum_q;
            fa_q <= '0;
            err_q <= psum_q;
            thr_q <= '0;
            first_q <= 1'b1;
          end else begin
            // compare only at the first entry of a group of equal scores
            if (first_q || rd_q.score != gd_q) begin
              gd_q <= rd_q.score;
              if (cur < err_q) begin
                err_q <= cur;
                thr_q <= {1'b0, rd_q.score};
              end
            end
            first_q <= 1'b0;
            if (rd_q.lab) fr_q <= fr_q - SumW'(rd_q.weight);
            else fa_q <= fa_q + SumW'(rd_q.weight);
          end
          if (i_q != cnt_q) i_q <= i_q + 1'b1;
        end
        SFinal: begin
          if (fa_q < err_q) begin
            err_q <= fa_q;
            thr_q <= AcceptAllThr;
          end
          tot_q <= {1'b0, psum_q} + {1'b0, nsum_q};
          rem_q <= '0;
          quo_q <= {best, 16'h0};
          dc_q <= 6'(DivW - 1);
        end
        SDiv: begin
          if (!trial[DivW]) begin
            rem_q <= trial[DivW-1:0];
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          if (dc_q != '0) dc_q <= dc_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign in_i.ready = (st_q == SIdle);
  assign out_o.valid = (st_q == SOut);
  assign out_o.best_threshold = thr_q;
  assign out_o.error_weight = err_q;
  assign out_o.error_fraction = (tot_q == '0) ? '0 :
    ((quo_q > DivW'(FracMax)) ? FracMax : quo_q[FracW-1:0]);

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity)) else $error("count above capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid) else $error("result lost");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_o.best_threshold) &&
    $stable(out_o.error_weight) && $stable(out_o.error_fraction))
    else $error("result changed while waiting");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("overlap");
`endif
endmodule

/* sim/tb_pkg.sv */
// shared item types for the weighted threshold cache testbench
// depends on wtc_pkg
package tb_pkg;
  import wtc_pkg::*;

  typedef struct {
    logic [DistW-1:0]   score;
    logic               lab;
    logic [WeightW-1:0] weight;
  } sample_t;

  typedef struct {
    logic [ThrW-1:0]  thr;
    logic [SumW-1:0]  err;
    logic [FracW-1:0] frac;
  } decision_t;
endpackage

/* sim/tb.sv */
// testbench for weighted_threshold_cache_top: drives scored, labelled samples,
// predicts the chosen threshold, error weight and error fraction, checks each result
// depends on wtc_pkg, wtc_if, tb_pkg and the rtl
module tb;
  import wtc_pkg::*;
  import tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  wtc_in_if  in_ch ();
  wtc_out_if out_ch ();

  weighted_threshold_cache_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state: sorted cache and label sums
  logic [DistW-1:0]   c_dist[$];
  logic               c_lab[$];
  logic [WeightW-1:0] c_wt[$];
  logic [SumW-1:0]    pos_sum, neg_sum;
  decision_t          pending_decisions[$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          burst_mode = 1'b1;

  function automatic decision_t predict_decision(sample_t s);
    int          ins_at, lightest;
    logic [SumW-1:0] fr, fa, best, cur;
    logic [DistW-1:0] gd;
    logic [SumW:0]    total;
    logic [SumW+16:0] q;
    decision_t   r;
    int          i;
    ins_at = 0;
    lightest = 0;
    for (i = 0; i < c_dist.size(); i++) begin
      if (c_wt[i] < c_wt[lightest]) lightest = i;
      if (s.score > c_dist[i]) ins_at = i + 1;
    end
    if (c_dist.size() < Capacity || s.weight > c_wt[lightest]) begin
      if (c_dist.size() >= Capacity) begin
        if (s.score > c_dist[lightest] && ins_at > 0) ins_at--;
        if (c_lab[lightest]) pos_sum -= SumW'(c_wt[lightest]);
        else neg_sum -= SumW'(c_wt[lightest]);
        c_dist.delete(lightest);
        c_lab.delete(lightest);
        c_wt.delete(lightest);
      end
      c_dist.insert(ins_at, s.score);
      c_lab.insert(ins_at, s.lab);
      c_wt.insert(ins_at, s.weight);
      if (s.lab) pos_sum += SumW'(s.weight);
      else neg_sum += SumW'(s.weight);
    end
    fr = pos_sum;
    fa = '0;
    best = fr;
    r.thr = '0;
    i = 0;
    while (i < c_dist.size()) begin
      gd = c_dist[i];
      cur = fr + fa;
      if (cur < best) begin
        r.thr = {1'b0, gd};
        best = cur;
      end
      while (i < c_dist.size() && c_dist[i] == gd) begin
        if (c_lab[i]) fr -= SumW'(c_wt[i]);
        else fa += SumW'(c_wt[i]);
        i++;
      end
    end
    if (fa < best) begin
      r.thr = AcceptAllThr;
      best = fa;
    end
    r.err = best;
    total = {1'b0, pos_sum} + {1'b0, neg_sum};
    if (total == 0) begin
      r.frac = '0;
    end else begin
      q = ({16'b0, best} << 16) / total;
      r.frac = (q > FracMax) ? FracMax : q[FracW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  task automatic send_sample(sample_t s);
    int unsigned gap;
    in_ch.valid           <= 1'b1;
    in_ch.sample_distance <= s.score;
    in_ch.label_positive  <= s.lab;
    in_ch.sample_weight   <= s.weight;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_decisions = {pending_decisions, predict_decision(s)};
    in_ch.valid <= 1'b0;
    // bursts of random length, then a gap
    gap = 1;
    if (burst_mode && $urandom_range(0, 5) == 0) gap = $urandom_range(2, 12);
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    decision_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected item", {31'b0, out_ch.best_threshold}, '0);
      end else begin
        want = pending_decisions[0];
        pending_decisions.delete(0);
        if (out_ch.best_threshold !== want.thr)
          report_mismatch("best_threshold", 64'(out_ch.best_threshold), 64'(want.thr));
        if (out_ch.error_weight !== want.err)
          report_mismatch("error_weight", 64'(out_ch.error_weight), 64'(want.err));
        if (out_ch.error_fraction !== want.frac)
          report_mismatch("error_fraction", 64'(out_ch.error_fraction), 64'(want.frac));
      end
    end
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic sample_t rand_sample(bit narrow);
    sample_t s;
    s.score  = narrow ? 32'($urandom_range(0, 40)) << 14 : $urandom;
    s.lab    = 1'($urandom_range(0, 1));
    s.weight = $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(1, 1 << 18));
    if (s.weight == 0) s.weight = 1;
    return s;
  endfunction

  task automatic test_extremes();
    sample_t s;
    s = '{32'h0, 1'b1, 32'h1};                   send_sample(s);
    s = '{32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF};   send_sample(s);
    s = '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF};   send_sample(s);
    s = '{32'h0, 1'b0, 32'h1};                   send_sample(s);
    s = '{32'h0001_0000, 1'b1, 32'h0001_0000};   send_sample(s);
    // equal score goes in front of existing entries
    s = '{32'h0001_0000, 1'b0, 32'h0002_0000};   send_sample(s);
    s = '{32'hAAAA_AAAA, 1'b1, 32'h5555_5555};   send_sample(s);
    s = '{32'h5555_5555, 1'b0, 32'hAAAA_AAAA};   send_sample(s);
    drain_results();
  endtask

  // fill the cache past capacity: evictions, ties on lightest, dropped items
  task automatic test_eviction();
    sample_t s;
    for (int i = 0; i < Capacity + 20; i++) begin
      s = rand_sample(1'b1);
      if (i % 3 == 0) s.weight = 32'd5;
      if (i >= Capacity && i % 2 == 0) s.weight = 32'd1;
      send_sample(s);
    end
    drain_results();
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        burst_mode = 1'b0;
        repeat (8) send_sample(rand_sample(1'b1));
        burst_mode = 1'b1;
      end
    join
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < 1050; i++) begin
      send_sample(rand_sample($urandom_range(0, 3) != 0));
      if (i == 500) drain_results();
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.sample_distance = '0;
    in_ch.label_positive  = 1'b0;
    in_ch.sample_weight   = '0;
    out_ch.ready          = 1'b0;
    pos_sum = '0;
    neg_sum = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_eviction();
    test_backpressure();
    test_random();
    repeat (700) @(posedge clk_i);
    if (errors == 0 && pending_decisions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
src/wtc_pkg.sv
src/wtc_if.sv
src/weighted_threshold_cache_top.sv
sim/tb_pkg.sv
sim/tb.sv
